// ----- sv/dispi_pkg.sv -----
package dispi_pkg;

	localparam int KNOWN_REGS = 12;
	localparam int REG_IDX_W  = $clog2(KNOWN_REGS);
	localparam int BANK_W     = 25;
	localparam int VRAM_W     = 11;

	localparam logic [15:0] MAX_X_RES = 16'd1920;
	localparam logic [15:0] MAX_Y_RES = 16'd1600;
	localparam logic [15:0] CAP_BPP   = 16'h0020;
	localparam logic [15:0] CAP_BANK  = 16'h1000;
	localparam logic [15:0] ID_LOW    = 16'hB0C0;
	localparam logic [15:0] ID_HIGH   = 16'hB0C5;
	localparam logic [15:0] DDC_IDLE  = 16'h000F;
	localparam logic [VRAM_W-1:0] VRAM_RESET = 11'd256;

	// Request kinds and host ports.
	localparam logic REQ_READ   = 1'b0;
	localparam logic REQ_WRITE  = 1'b1;
	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	// Register indexes on the data port.
	localparam logic [15:0] IDX_ID          = 16'd0;
	localparam logic [15:0] IDX_XRES        = 16'd1;
	localparam logic [15:0] IDX_YRES        = 16'd2;
	localparam logic [15:0] IDX_BPP         = 16'd3;
	localparam logic [15:0] IDX_ENABLE      = 16'd4;
	localparam logic [15:0] IDX_BANK        = 16'd5;
	localparam logic [15:0] IDX_VIRT_WIDTH  = 16'd6;
	localparam logic [15:0] IDX_VIRT_HEIGHT = 16'd7;
	localparam logic [15:0] IDX_X_OFFSET    = 16'd8;
	localparam logic [15:0] IDX_Y_OFFSET    = 16'd9;
	localparam logic [15:0] IDX_VRAM_SIZE   = 16'd10;
	localparam logic [15:0] IDX_DDC         = 16'd11;

	typedef struct packed {
		logic        req_type;
		logic        port_sel;
		logic [15:0] data_in;
		logic        ddc_scl_in;
		logic        ddc_sda_in;
	} dispi_req_t;

	typedef struct packed {
		logic [15:0]       read_data;
		logic [BANK_W-1:0] read_bank_addr;
		logic [BANK_W-1:0] write_bank_addr;
		logic              mode_changed;
		logic              clear_memory;
		logic              dac_wide;
		logic              ddc_drive;
		logic              ddc_scl_out;
		logic              ddc_sda_out;
	} dispi_rsp_t;

endpackage

// ----- sv/display_interface_register_file_core.sv -----
// Index/data register block of a display extension interface.
// A host request comes in on in_valid/in_stall: req_type selects read or write,
// port_sel the index port or the data port, data_in carries write data, and the
// DDC line levels are sampled with the request. Each request gives exactly one
// result on out_valid/out_stall: read data, the current read and write bank
// byte offsets, the mode-change and memory-clear pulses, the DAC width and the
// DDC drive levels.
// A request is registered at the input, decoded against the register state in
// one pass, and the result lands in the output register and raises out_valid once
// that register is empty or its held result is taken. One request is taken per
// cycle while the receiver does not stall; the rate is set by the decode and
// state update between the two registers.
// When the receiver stalls, the held result stays put and the input register
// keeps at most one more request; after that in_stall is raised.
// The memory size register is written on cfg_valid/cfg_ready; cfg_ready is
// always high. Reset clears the index, mode and bank registers, selects 64 KiB banks and a 6-bit
// DAC, and sets the memory size to 256 units of 64 KiB.
module display_interface_register_file_core
	import dispi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [VRAM_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic              port_sel,
	input  logic [15:0]       data_in,
	input  logic              ddc_scl_in,
	input  logic              ddc_sda_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       read_data,
	output logic [BANK_W-1:0] read_bank_addr,
	output logic [BANK_W-1:0] write_bank_addr,
	output logic              mode_changed,
	output logic              clear_memory,
	output logic              dac_wide,
	output logic              ddc_drive,
	output logic              ddc_scl_out,
	output logic              ddc_sda_out
);

	dispi_req_t in_req;
	dispi_req_t req_s1;
	dispi_rsp_t rsp;
	dispi_rsp_t rsp_q;
	logic       valid_s1;
	logic       out_valid_q;
	logic       advance;

	assign in_req = '{req_type: req_type, port_sel: port_sel, data_in: data_in,
		ddc_scl_in: ddc_scl_in, ddc_sda_in: ddc_sda_in};

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);

	dispi_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_req   (in_req),
		.advance  (advance),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	dispi_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.fire     (advance),
		.req_s1   (req_s1),
		.rsp      (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp;
		end
	end

	assign out_valid       = out_valid_q;
	assign read_data       = rsp_q.read_data;
	assign read_bank_addr  = rsp_q.read_bank_addr;
	assign write_bank_addr = rsp_q.write_bank_addr;
	assign mode_changed    = rsp_q.mode_changed;
	assign clear_memory    = rsp_q.clear_memory;
	assign dac_wide        = rsp_q.dac_wide;
	assign ddc_drive       = rsp_q.ddc_drive;
	assign ddc_scl_out     = rsp_q.ddc_scl_out;
	assign ddc_sda_out     = rsp_q.ddc_sda_out;

endmodule

// ----- sv/dispi_in_reg.sv -----
module dispi_in_reg
	import dispi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  dispi_req_t in_req,
	input  logic       advance,
	output logic       in_stall,
	output logic       valid_s1,
	output dispi_req_t req_s1
);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_req;
		end
	end

endmodule

// ----- sv/dispi_regfile.sv -----
module dispi_regfile
	import dispi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [VRAM_W-1:0] cfg_data,
	input  logic              fire,
	input  dispi_req_t        req_s1,
	output dispi_rsp_t        rsp
);

	logic [15:0]       index_q;
	logic [15:0]       regs_q [KNOWN_REGS];
	logic              gran32_q;
	logic [BANK_W-1:0] rbank_q;
	logic [BANK_W-1:0] wbank_q;
	logic              dac8_q;
	logic [VRAM_W-1:0] vram_q;

	logic [15:0]       index_d;
	logic [15:0]       regs_d [KNOWN_REGS];
	logic              gran32_d;
	logic [BANK_W-1:0] rbank_d;
	logic [BANK_W-1:0] wbank_d;
	logic              dac8_d;

	logic [15:0]       sel_reg;
	logic [15:0]       ddc_reg;
	logic [15:0]       enable_reg;
	logic              caps;
	logic [BANK_W-1:0] bank_addr;
	logic [1:0]        bank_sel;
	logic [15:0]       val;

	assign val        = req_s1.data_in;
	assign enable_reg = regs_q[REG_IDX_W'(IDX_ENABLE)];
	assign ddc_reg    = regs_q[REG_IDX_W'(IDX_DDC)];
	assign caps       = enable_reg[1];
	assign sel_reg    = (index_q < 16'(KNOWN_REGS)) ? regs_q[index_q[REG_IDX_W-1:0]] : 16'h0000;

	// Bank offset is the 9-bit bank number times 32 KiB or 64 KiB.
	assign bank_addr = gran32_q ? {1'b0, val[8:0], 15'h0000} : {val[8:0], 16'h0000};
	assign bank_sel  = (val[15:14] == 2'b00) ? 2'b11 : val[15:14];

	always_comb begin
		index_d  = index_q;
		regs_d   = regs_q;
		gran32_d = gran32_q;
		rbank_d  = rbank_q;
		wbank_d  = wbank_q;
		dac8_d   = dac8_q;
		rsp      = '0;

		if (req_s1.req_type == REQ_READ) begin
			if (req_s1.port_sel == PORT_INDEX) begin
				rsp.read_data = index_q;
			end else begin
				case (index_q)
					IDX_XRES:      rsp.read_data = caps ? MAX_X_RES : sel_reg;
					IDX_YRES:      rsp.read_data = caps ? MAX_Y_RES : sel_reg;
					IDX_BPP:       rsp.read_data = caps ? CAP_BPP : sel_reg;
					IDX_BANK:      rsp.read_data = caps ? CAP_BANK : sel_reg;
					IDX_VRAM_SIZE: rsp.read_data = 16'(vram_q);
					IDX_DDC: begin
						if (ddc_reg[7]) begin
							rsp.read_data = {8'h00, ddc_reg[7], 3'b000,
								req_s1.ddc_sda_in, req_s1.ddc_scl_in, ddc_reg[1:0]};
						end else begin
							rsp.read_data = DDC_IDLE;
						end
					end
					default:       rsp.read_data = sel_reg;
				endcase
			end
		end else if (req_s1.port_sel == PORT_INDEX) begin
			index_d = val;
		end else begin
			case (index_q)
				IDX_ID: begin
					if (val >= ID_LOW && val <= ID_HIGH) begin
						regs_d[REG_IDX_W'(IDX_ID)] = val;
					end
				end
				IDX_XRES, IDX_YRES, IDX_BPP, IDX_VIRT_WIDTH, IDX_X_OFFSET,
				IDX_Y_OFFSET: begin
					regs_d[index_q[REG_IDX_W-1:0]] = val;
					rsp.mode_changed = 1'b1;
				end
				IDX_BANK: begin
					regs_d[REG_IDX_W'(IDX_BANK)] = val;
					if (bank_sel[1]) begin
						rbank_d = bank_addr;
					end
					if (bank_sel[0]) begin
						wbank_d = bank_addr;
					end
				end
				IDX_DDC: begin
					if (val[7]) begin
						rsp.ddc_drive   = 1'b1;
						rsp.ddc_scl_out = val[0];
						rsp.ddc_sda_out = val[1];
						regs_d[REG_IDX_W'(IDX_DDC)] = val;
					end else begin
						regs_d[REG_IDX_W'(IDX_DDC)] = {ddc_reg[15:8], 1'b0, ddc_reg[6:0]};
					end
				end
				IDX_ENABLE: begin
					// A fresh enable is judged against the enable bit held before this write.
					if (val[0] && !enable_reg[0]) begin
						regs_d[REG_IDX_W'(IDX_X_OFFSET)]   = 16'h0000;
						regs_d[REG_IDX_W'(IDX_Y_OFFSET)]   = 16'h0000;
						regs_d[REG_IDX_W'(IDX_VIRT_WIDTH)] = 16'h0000;
						rsp.mode_changed = 1'b1;
						rsp.clear_memory = !val[7];
					end else begin
						rbank_d = '0;
						wbank_d = '0;
					end
					if (val[4] != gran32_q) begin
						gran32_d = val[4];
						rbank_d  = '0;
						wbank_d  = '0;
					end
					dac8_d = val[5];
					regs_d[REG_IDX_W'(IDX_ENABLE)] = {val[15:8], 1'b0, val[6:0]};
				end
				default: begin
				end
			endcase
		end

		rsp.read_bank_addr  = rbank_d;
		rsp.write_bank_addr = wbank_d;
		rsp.dac_wide        = dac8_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q  <= '0;
			gran32_q <= 1'b0;
			rbank_q  <= '0;
			wbank_q  <= '0;
			dac8_q   <= 1'b0;
			vram_q   <= VRAM_RESET;
			for (int i = 0; i < KNOWN_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				vram_q <= cfg_data;
			end
			if (fire) begin
				index_q  <= index_d;
				regs_q   <= regs_d;
				gran32_q <= gran32_d;
				rbank_q  <= rbank_d;
				wbank_q  <= wbank_d;
				dac8_q   <= dac8_d;
			end
		end
	end

endmodule

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dispi_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE       = 8;
	localparam int PHASE_ITEMS  = 400;
	localparam int LONG_HOLD    = 300;

	// Bit positions inside the enable, bank and DDC registers.
	localparam int EN_BIT     = 0;
	localparam int CAPS_BIT   = 1;
	localparam int GRAN_BIT   = 4;
	localparam int DAC_BIT    = 5;
	localparam int NOCLR_BIT  = 7;
	localparam int DDC_ON_BIT = 7;
	localparam int RD_SEL_BIT = 15;
	localparam int WR_SEL_BIT = 14;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic [VRAM_W-1:0] cfg_data   = VRAM_RESET;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic              req_type   = REQ_READ;
	logic              port_sel   = PORT_INDEX;
	logic [15:0]       data_in    = 16'h0000;
	logic              ddc_scl_in = 1'b0;
	logic              ddc_sda_in = 1'b0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [15:0]       read_data;
	logic [BANK_W-1:0] read_bank_addr;
	logic [BANK_W-1:0] write_bank_addr;
	logic              mode_changed;
	logic              clear_memory;
	logic              dac_wide;
	logic              ddc_drive;
	logic              ddc_scl_out;
	logic              ddc_sda_out;

	display_interface_register_file_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.port_sel        (port_sel),
		.data_in         (data_in),
		.ddc_scl_in      (ddc_scl_in),
		.ddc_sda_in      (ddc_sda_in),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.read_bank_addr  (read_bank_addr),
		.write_bank_addr (write_bank_addr),
		.mode_changed    (mode_changed),
		.clear_memory    (clear_memory),
		.dac_wide        (dac_wide),
		.ddc_drive       (ddc_drive),
		.ddc_scl_out     (ddc_scl_out),
		.ddc_sda_out     (ddc_sda_out)
	);

	always #10 clk = ~clk;

	// Shadow copy of the register block state.
	logic [15:0]       host_index = 16'h0000;
	logic [15:0]       mode_regs [KNOWN_REGS] = '{default: 16'h0000};
	logic              gran_32k   = 1'b0;
	logic              dac_8bit   = 1'b0;
	logic [BANK_W-1:0] rd_bank    = '0;
	logic [BANK_W-1:0] wr_bank    = '0;
	logic [VRAM_W-1:0] vram_units = VRAM_RESET;

	dispi_rsp_t pending_rsp [$];
	int         errors      = 0;
	int         idle_cycles = 0;
	int         burst_left  = 0;
	bit         offering    = 1'b0;
	bit         steady_send = 1'b0;
	bit         hold_request = 1'b0;
	int         hold_left   = 0;
	int         rx_mode     = 0;
	int         mode_left   = 0;
	int         rx_tick     = 0;

	function automatic logic [REG_IDX_W-1:0] slot(input logic [15:0] idx);
		return idx[REG_IDX_W-1:0];
	endfunction

	function automatic logic [15:0] stored(input logic [15:0] idx);
		return (idx < 16'(KNOWN_REGS)) ? mode_regs[slot(idx)] : 16'h0000;
	endfunction

	task automatic apply_request(input dispi_req_t r);
		dispi_rsp_t        e;
		logic [15:0]       old_en;
		logic [15:0]       ddc;
		logic [BANK_W-1:0] offset;
		logic [1:0]        sel;
		e = '0;
		old_en = stored(IDX_ENABLE);
		if (r.req_type == REQ_READ) begin
			if (r.port_sel == PORT_INDEX) begin
				e.read_data = host_index;
			end else begin
				case (host_index)
				IDX_XRES: e.read_data = old_en[CAPS_BIT] ? MAX_X_RES : stored(host_index);
				IDX_YRES: e.read_data = old_en[CAPS_BIT] ? MAX_Y_RES : stored(host_index);
				IDX_BPP:  e.read_data = old_en[CAPS_BIT] ? CAP_BPP : stored(host_index);
				IDX_BANK: e.read_data = old_en[CAPS_BIT] ? CAP_BANK : stored(host_index);
				IDX_VRAM_SIZE: e.read_data = 16'(vram_units);
				IDX_DDC: begin
					ddc = stored(IDX_DDC);
					if (ddc[DDC_ON_BIT])
						e.read_data = (ddc & 16'h0083) |
							{12'd0, r.ddc_sda_in, r.ddc_scl_in, 2'b00};
					else
						e.read_data = DDC_IDLE;
				end
				default: e.read_data = stored(host_index);
				endcase
			end
		end else if (r.port_sel == PORT_INDEX) begin
			host_index = r.data_in;
		end else begin
			case (host_index)
			IDX_ID: begin
				if (r.data_in >= ID_LOW && r.data_in <= ID_HIGH)
					mode_regs[slot(IDX_ID)] = r.data_in;
			end
			IDX_XRES, IDX_YRES, IDX_BPP, IDX_VIRT_WIDTH, IDX_X_OFFSET, IDX_Y_OFFSET: begin
				mode_regs[slot(host_index)] = r.data_in;
				e.mode_changed = 1'b1;
			end
			IDX_BANK: begin
				offset = gran_32k ? {1'b0, r.data_in[8:0], 15'd0} : {r.data_in[8:0], 16'd0};
				sel = r.data_in[RD_SEL_BIT:WR_SEL_BIT];
				// Neither select bit means both banks move together.
				if (sel == 2'b00)
					sel = 2'b11;
				mode_regs[slot(IDX_BANK)] = r.data_in;
				if (sel[1])
					rd_bank = offset;
				if (sel[0])
					wr_bank = offset;
			end
			IDX_DDC: begin
				if (r.data_in[DDC_ON_BIT]) begin
					e.ddc_drive   = 1'b1;
					e.ddc_scl_out = r.data_in[0];
					e.ddc_sda_out = r.data_in[1];
					mode_regs[slot(IDX_DDC)] = r.data_in;
				end else begin
					mode_regs[slot(IDX_DDC)][DDC_ON_BIT] = 1'b0;
				end
			end
			IDX_ENABLE: begin
				if (r.data_in[EN_BIT] && !old_en[EN_BIT]) begin
					mode_regs[slot(IDX_X_OFFSET)]   = 16'h0000;
					mode_regs[slot(IDX_Y_OFFSET)]   = 16'h0000;
					mode_regs[slot(IDX_VIRT_WIDTH)] = 16'h0000;
					e.mode_changed = 1'b1;
					e.clear_memory = !r.data_in[NOCLR_BIT];
				end else begin
					rd_bank = '0;
					wr_bank = '0;
				end
				if (r.data_in[GRAN_BIT] != gran_32k) begin
					gran_32k = r.data_in[GRAN_BIT];
					rd_bank = '0;
					wr_bank = '0;
				end
				dac_8bit = r.data_in[DAC_BIT];
				mode_regs[slot(IDX_ENABLE)] = r.data_in;
				mode_regs[slot(IDX_ENABLE)][NOCLR_BIT] = 1'b0;
			end
			default: ;
			endcase
		end
		e.read_bank_addr  = rd_bank;
		e.write_bank_addr = wr_bank;
		e.dac_wide        = dac_8bit;
		pending_rsp.push_back(e);
	endtask

	task automatic release_input();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic send_request(input logic kind, input logic port, input logic [15:0] value);
		dispi_req_t r;
		int         gap;
		r.req_type   = kind;
		r.port_sel   = port;
		r.data_in    = value;
		r.ddc_scl_in = 1'($urandom);
		r.ddc_sda_in = 1'($urandom);
		if (!steady_send && burst_left == 0) begin
			gap = $urandom_range(1, 12);
			release_input();
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 32);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid   <= 1'b1;
		offering   = 1'b1;
		req_type   <= r.req_type;
		port_sel   <= r.port_sel;
		data_in    <= r.data_in;
		ddc_scl_in <= r.ddc_scl_in;
		ddc_sda_in <= r.ddc_sda_in;
		do @(posedge clk); while (in_stall);
		apply_request(r);
	endtask

	task automatic select_reg(input logic [15:0] idx);
		send_request(REQ_WRITE, PORT_INDEX, idx);
	endtask

	task automatic write_reg(input logic [15:0] value);
		send_request(REQ_WRITE, PORT_DATA, value);
	endtask

	task automatic read_reg();
		send_request(REQ_READ, PORT_DATA, 16'($urandom));
	endtask

	task automatic finish_outstanding();
		release_input();
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic set_vram_size(input logic [VRAM_W-1:0] units);
		finish_outstanding();
		cfg_valid <= 1'b1;
		cfg_data  <= units;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vram_units = units;
	endtask

	function automatic logic [15:0] pick_value(input logic [15:0] idx);
		case ($urandom_range(0, 7))
		0: return 16'h0000;
		1: return 16'hFFFF;
		2, 3: begin
			// Land near the window of accepted IDs, edges included.
			if (idx == IDX_ID)
				return ID_LOW - 16'd1 + 16'($urandom_range(0, 7));
			return 16'($urandom);
		end
		default: return 16'($urandom);
		endcase
	endfunction

	// Mostly an index select followed by a few data accesses, sometimes a stray request.
	task automatic random_sequence(output int sent);
		logic [15:0] idx;
		int          n;
		if ($urandom_range(0, 9) < 8) begin
			if ($urandom_range(0, 15) == 0)
				idx = 16'($urandom);
			else
				idx = 16'($urandom_range(0, KNOWN_REGS));
			select_reg(idx);
			n = $urandom_range(1, 4);
			repeat (n) begin
				if ($urandom_range(0, 1))
					read_reg();
				else
					write_reg(pick_value(idx));
			end
			sent = n + 1;
		end else begin
			send_request(1'($urandom), 1'($urandom), 16'($urandom));
			sent = 1;
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		dispi_rsp_t e;
		if (pending_rsp.size() == 0) begin
			$display("%0t: result with no request outstanding, read_data %h",
				$time, read_data);
			errors++;
		end else begin
			e = pending_rsp.pop_front();
			compare_field("read_data", 32'(e.read_data), 32'(read_data));
			compare_field("read_bank_addr", 32'(e.read_bank_addr), 32'(read_bank_addr));
			compare_field("write_bank_addr", 32'(e.write_bank_addr),
				32'(write_bank_addr));
			compare_field("mode_changed", 32'(e.mode_changed), 32'(mode_changed));
			compare_field("clear_memory", 32'(e.clear_memory), 32'(clear_memory));
			compare_field("dac_wide", 32'(e.dac_wide), 32'(dac_wide));
			compare_field("ddc_drive", 32'(e.ddc_drive), 32'(ddc_drive));
			compare_field("ddc_scl_out", 32'(e.ddc_scl_out), 32'(ddc_scl_out));
			compare_field("ddc_sda_out", 32'(e.ddc_sda_out), 32'(ddc_sda_out));
		end
	endtask

	// Result checking and the receiver's stall pattern.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			check_result();
		rx_tick++;
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 128);
			end else begin
				mode_left--;
			end
			case (rx_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((rx_tick % 5) < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, idle_cycles);
			$display("display_interface_register_file_core regression: fail");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	task automatic test_reset_state();
		send_request(REQ_READ, PORT_INDEX, 16'($urandom));
		select_reg(IDX_VRAM_SIZE);
		read_reg();
		select_reg(IDX_DDC);
		read_reg();
		select_reg(16'hFFFF);
		read_reg();
		write_reg(16'hFFFF);
	endtask

	task automatic test_id_register();
		select_reg(IDX_ID);
		write_reg(ID_HIGH);
		write_reg(ID_HIGH + 16'd1);
		read_reg();
	endtask

	task automatic test_enable_and_banks();
		select_reg(IDX_ENABLE);
		// Fresh enable with capabilities, 32K banks, 8-bit DAC and no clear.
		write_reg(16'h00B3);
		select_reg(IDX_XRES);
		read_reg();
		select_reg(IDX_BANK);
		read_reg();
		write_reg(16'h81FF);
		write_reg(16'h4001);
		write_reg(16'h01FF);
		select_reg(IDX_ENABLE);
		write_reg(16'h0000);
		write_reg(16'h0001);
		read_reg();
		select_reg(IDX_XRES);
		write_reg(16'hFFFF);
	endtask

	task automatic test_ddc_lines();
		select_reg(IDX_DDC);
		write_reg(16'h0083);
		read_reg();
		write_reg(16'h0000);
		read_reg();
	endtask

	task automatic test_memory_size();
		set_vram_size(11'd1);
		select_reg(IDX_VRAM_SIZE);
		read_reg();
		set_vram_size(11'd1024);
		read_reg();
	endtask

	task automatic test_full_backpressure();
		int sent;
		int total;
		total = 0;
		steady_send = 1'b1;
		hold_request = 1'b1;
		while (total < 40) begin
			random_sequence(sent);
			total += sent;
		end
		steady_send = 1'b0;
		finish_outstanding();
	endtask

	task automatic test_random_traffic();
		int sent;
		int total;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: set_vram_size(11'd1024);
			1: set_vram_size(11'($urandom_range(2, 1023)));
			2: set_vram_size(11'd1);
			default: set_vram_size(VRAM_RESET);
			endcase
			steady_send = (phase == 0);
			total = 0;
			while (total < PHASE_ITEMS) begin
				random_sequence(sent);
				total += sent;
			end
		end
		steady_send = 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_id_register();
		test_enable_and_banks();
		test_ddc_lines();
		test_memory_size();
		test_full_backpressure();
		test_random_traffic();
		finish_outstanding();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("display_interface_register_file_core regression: pass");
		end else begin
			$display("display_interface_register_file_core regression: fail");
		end
		$finish;
	end

endmodule

// ----- display_interface_register_file_core.f -----
sv/dispi_pkg.sv
sv/dispi_in_reg.sv
sv/dispi_regfile.sv
sv/display_interface_register_file_core.sv
dv/testbench.sv
